>>> rtl/core/rv32i_pkg.sv
// ---------------------------------------------------------------------------
// rv32i package
// shared opcodes, memory codes and field widths of the rv32i executor
// ---------------------------------------------------------------------------
package rv32i_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int REG_COUNT  = 32;

   typedef enum logic [6:0] {
      OPC_LOAD   = 7'b0000011,
      OPC_STORE  = 7'b0100011,
      OPC_OPIMM  = 7'b0010011,
      OPC_OP     = 7'b0110011,
      OPC_AUIPC  = 7'b0010111,
      OPC_LUI    = 7'b0110111,
      OPC_BRANCH = 7'b1100011,
      OPC_JALR   = 7'b1100111,
      OPC_JAL    = 7'b1101111
   } opcode_type;

   typedef enum logic [1:0] {
      MEM_NONE  = 2'd0,
      MEM_READ  = 2'd1,
      MEM_WRITE = 2'd2
   } mem_op_type;

   typedef enum logic [1:0] {
      CSR_RESET_VECTOR = 2'd0,
      CSR_HOST_MAILBOX = 2'd1,
      CSR_TIMER_ADDR   = 2'd2,
      CSR_CYCLE_LIMIT  = 2'd3
   } csr_index_type;

   localparam logic [31:0] HOST_CHAR_BIT  = 32'h0001_0000;
   localparam logic [31:0] HOST_HALT_BIT  = 32'h0002_0000;
   localparam logic [11:0] SRA_IMM_BIT    = 12'h400;
   localparam logic [31:0] UPPER_IMM_MASK = 32'hffff_f000;
   localparam logic [31:0] STORE_IMM_MASK = 32'hffff_ffe0;

   localparam logic [31:0] MAILBOX_RESET = 32'd4096;
   localparam logic [31:0] TIMER_RESET   = 32'd8192;
   localparam logic [31:0] LIMIT_RESET   = 32'd1000000;

endpackage

>>> rtl/core/rv32i_instruction_executor.sv
// ---------------------------------------------------------------------------
// rv32i instruction executor
// executes one rv32i instruction or load return per transfer
// ---------------------------------------------------------------------------
// the response is registered and valid in the cycle after the request is accepted
// throughput: one request per cycle unless a stalled response fills the slot, set by the
//   register file read and the single alu/branch pass that writes the architectural state
// reset: synchronous; register file cleared through per-entry valid bits,
//   pc clears to zero, control registers take their reset values
module rv32i_instruction_executor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_opcode,
   input  logic [31:0]                      req_instr_word,
   input  logic [rv32i_pkg::DATA_WIDTH-1:0] req_read_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [31:0]                      rsp_next_fetch_pc,
   output logic [1:0]                       rsp_mem_op,
   output logic [1:0]                       rsp_mem_size,
   output logic [31:0]                      rsp_mem_addr,
   output logic [rv32i_pkg::DATA_WIDTH-1:0] rsp_mem_wdata,
   output logic                             rsp_console_valid,
   output logic [7:0]                       rsp_console_char,
   output logic                             rsp_halted,
   output logic                             rsp_illegal,
   output logic                             rsp_retired,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [1:0]                       csr_index,
   input  logic [31:0]                      csr_data
);
   import rv32i_pkg::*;

   localparam int RW = $clog2(REG_COUNT);

   // configuration
   logic [31:0] mailbox_ff, timer_ff, limit_ff;

   // architectural state
   logic [DATA_WIDTH-1:0] regs_ff [REG_COUNT];
   logic [REG_COUNT-1:0]  rvalid_ff;
   logic [31:0] pc_ff, pc_in;
   logic        lpend_ff, lpend_in;
   logic [RW-1:0] ldest_ff, ldest_in;
   logic [2:0]  lkind_ff, lkind_in;
   logic        ltimer_ff, ltimer_in;
   logic [31:0] count_ff, count_in;
   logic        halt_ff, halt_in;

   // response register
   logic        rvld_ff;
   logic [31:0] o_pc_ff, o_addr_ff;
   logic [1:0]  o_op_ff, o_size_ff;
   logic [DATA_WIDTH-1:0] o_wdata_ff;
   logic        o_cv_ff, o_halt_ff, o_ill_ff, o_ret_ff;
   logic [7:0]  o_char_ff;

   logic [1:0]  o_op_in, o_size_in;
   logic [31:0] o_addr_in;
   logic [DATA_WIDTH-1:0] o_wdata_in;
   logic        o_cv_in, o_ill_in, o_ret_in;
   logic [7:0]  o_char_in;

   logic        take;
   logic        wen;
   logic [RW-1:0] waddr;
   logic [DATA_WIDTH-1:0] wdata;

   // ready whenever the response slot is empty or being drained this cycle
   assign req_ready = !rvld_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // decode fields
   logic [6:0]  opc, f7;
   logic [2:0]  f3;
   logic [RW-1:0] rd, rs1, rs2;
   logic [31:0] a, b, immi, npc, d, addr_s, addr_l, bimm, jimm, ld;
   logic        bad, wr, cond, hhalt;

   assign opc = req_instr_word[6:0];
   assign f3  = req_instr_word[14:12];
   assign f7  = req_instr_word[31:25];
   assign rd  = req_instr_word[7+RW-1:7];
   assign rs1 = req_instr_word[15+RW-1:15];
   assign rs2 = req_instr_word[20+RW-1:20];
   // entries not yet written since reset read as zero
   assign a   = rvalid_ff[rs1] ? regs_ff[rs1] : '0;
   assign b   = rvalid_ff[rs2] ? regs_ff[rs2] : '0;
   assign immi   = {{20{req_instr_word[31]}}, req_instr_word[31:20]};
   assign addr_l = a + immi;
   assign addr_s = a + ((immi & STORE_IMM_MASK) | {27'd0, req_instr_word[11:7]});
   assign bimm = {{20{req_instr_word[31]}}, req_instr_word[7], req_instr_word[30:25],
                  req_instr_word[11:8], 1'b0};
   assign jimm = {{12{req_instr_word[31]}}, req_instr_word[19:12], req_instr_word[20],
                  req_instr_word[30:21], 1'b0};

   always_comb begin
      // load return extension
      ld = ltimer_ff ? '0 : req_read_data;
      case (lkind_ff)
         3'd0: ld = {{24{ld[7]}}, ld[7:0]};
         3'd1: ld = {{16{ld[15]}}, ld[15:0]};
         3'd4: ld = {24'd0, ld[7:0]};
         3'd5: ld = {16'd0, ld[15:0]};
         default: ;
      endcase
   end

   always_comb begin
      bad = 1'b0; wr = 1'b0; cond = 1'b0; hhalt = 1'b0;
      d = '0; npc = pc_ff + 32'd4;
      o_op_in = MEM_NONE; o_size_in = 2'd0; o_addr_in = '0; o_wdata_in = '0;
      o_cv_in = 1'b0; o_char_in = '0;
      unique case (opc)
         OPC_LOAD: begin
            if (f3 == 3'd3 || f3 >= 3'd6) bad = 1'b1;
            else begin
               o_op_in = MEM_READ; o_size_in = f3[1:0]; o_addr_in = addr_l;
            end
         end
         OPC_STORE: begin
            if (f3 > 3'd2) bad = 1'b1;
            else if (f3 == 3'd2 && addr_s == mailbox_ff) begin
               if ((b & HOST_CHAR_BIT) != '0) begin
                  o_cv_in = 1'b1; o_char_in = b[7:0];
               end
               hhalt = (b & HOST_HALT_BIT) != '0;
            end else begin
               o_op_in = MEM_WRITE; o_size_in = f3[1:0];
               o_addr_in = addr_s; o_wdata_in = b;
            end
         end
         OPC_OPIMM: begin
            wr = 1'b1;
            case (f3)
               3'd0: d = a + immi;
               3'd1: if (immi[11:5] != 7'd0) bad = 1'b1;
                     else d = a << immi[4:0];
               3'd2: d = {31'd0, $signed(a) < $signed(immi)};
               3'd3: d = {31'd0, a < immi};
               3'd4: d = a ^ immi;
               3'd5: if ((immi[11:0] & ~(12'd31 | SRA_IMM_BIT)) != 12'd0) bad = 1'b1;
                     else if (immi[10]) d = $unsigned($signed(a) >>> immi[4:0]);
                     else d = a >> immi[4:0];
               3'd6: d = a | immi;
               default: d = a & immi;
            endcase
         end
         OPC_OP: begin
            wr = 1'b1;
            if (f7 != 7'd0 && !(f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))) bad = 1'b1;
            case (f3)
               3'd0: d = (f7 != 7'd0) ? a - b : a + b;
               3'd1: d = a << b[4:0];
               3'd2: d = {31'd0, $signed(a) < $signed(b)};
               3'd3: d = {31'd0, a < b};
               3'd4: d = a ^ b;
               3'd5: d = (f7 != 7'd0) ? $unsigned($signed(a) >>> b[4:0]) : a >> b[4:0];
               3'd6: d = a | b;
               default: d = a & b;
            endcase
         end
         OPC_AUIPC: begin wr = 1'b1; d = pc_ff + (req_instr_word & UPPER_IMM_MASK); end
         OPC_LUI:   begin wr = 1'b1; d = req_instr_word & UPPER_IMM_MASK; end
         OPC_BRANCH: begin
            case (f3)
               3'd0: cond = a == b;
               3'd1: cond = a != b;
               3'd4: cond = $signed(a) < $signed(b);
               3'd5: cond = !($signed(a) < $signed(b));
               3'd6: cond = a < b;
               3'd7: cond = a >= b;
               default: bad = 1'b1;
            endcase
            if (cond) npc = pc_ff + bimm;
         end
         OPC_JALR: begin
            if (f3 != 3'd0) bad = 1'b1;
            wr = 1'b1; d = pc_ff + 32'd4;
            npc = addr_l & ~32'd1;
         end
         OPC_JAL: begin
            wr = 1'b1; d = pc_ff + 32'd4; npc = pc_ff + jimm;
         end
         default: bad = 1'b1;
      endcase
   end

   // next state for one accepted transfer
   always_comb begin
      pc_in = pc_ff; lpend_in = lpend_ff; ldest_in = ldest_ff; lkind_in = lkind_ff;
      ltimer_in = ltimer_ff; count_in = count_ff; halt_in = halt_ff;
      wen = 1'b0; waddr = rd; wdata = d;
      o_ill_in = 1'b0; o_ret_in = 1'b0;
      if (halt_ff) begin
         // halted: everything ignored
      end else if (req_opcode) begin
         if (lpend_ff) begin
            wen = 1'b1; waddr = ldest_ff; wdata = ld;
            lpend_in = 1'b0; ltimer_in = 1'b0; o_ret_in = 1'b1;
         end
      end else if (!lpend_ff) begin
         if (bad) begin
            o_ill_in = 1'b1; halt_in = 1'b1;
         end else if (opc == OPC_LOAD) begin
            lpend_in = 1'b1; ldest_in = rd; lkind_in = f3;
            ltimer_in = addr_l == timer_ff; pc_in = npc;
         end else begin
            wen = wr; pc_in = npc; o_ret_in = 1'b1;
            if (hhalt) halt_in = 1'b1;
         end
      end
      if (o_ret_in) begin
         count_in = count_ff + 32'd1;
         if (count_in >= limit_ff) halt_in = 1'b1;
      end
   end

   logic keep;  // memory and console fields only on a live execute
   assign keep = !halt_ff && !req_opcode && !lpend_ff && !bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         mailbox_ff <= MAILBOX_RESET;
         timer_ff   <= TIMER_RESET;
         limit_ff   <= LIMIT_RESET;
         pc_ff      <= '0;
         rvalid_ff  <= '0;
         lpend_ff   <= 1'b0;
         ldest_ff   <= '0;
         lkind_ff   <= '0;
         ltimer_ff  <= 1'b0;
         count_ff   <= '0;
         halt_ff    <= 1'b0;
         rvld_ff    <= 1'b0;
      end else begin
         // a reset vector write reloads the pc
         if (csr_valid && csr_index == CSR_RESET_VECTOR) pc_ff <= csr_data;
         else if (take) pc_ff <= pc_in;
         if (take) begin
            lpend_ff <= lpend_in; ldest_ff <= ldest_in;
            lkind_ff <= lkind_in; ltimer_ff <= ltimer_in;
            count_ff <= count_in; halt_ff <= halt_in;
            if (wen && waddr != '0) rvalid_ff[waddr] <= 1'b1;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_RESET_VECTOR: ;
               CSR_HOST_MAILBOX: mailbox_ff <= csr_data;
               CSR_TIMER_ADDR:   timer_ff <= csr_data;
               default:          limit_ff <= csr_data;
            endcase
         end
         if (take) rvld_ff <= 1'b1;
         else if (rsp_ready) rvld_ff <= 1'b0;
      end
   end

   // register file and response payload
   always_ff @(posedge clock) begin
      if (take && wen && waddr != '0) regs_ff[waddr] <= wdata;
      if (take) begin
         o_pc_ff    <= pc_in;
         o_halt_ff  <= halt_in;
         o_ill_ff   <= o_ill_in;
         o_ret_ff   <= o_ret_in;
         o_op_ff    <= keep ? o_op_in : MEM_NONE;
         o_size_ff  <= keep ? o_size_in : 2'd0;
         o_addr_ff  <= keep ? o_addr_in : '0;
         o_wdata_ff <= keep ? o_wdata_in : '0;
         o_cv_ff    <= keep && o_cv_in;
         o_char_ff  <= keep ? o_char_in : '0;
      end
   end

   assign rsp_valid         = rvld_ff;
   assign rsp_next_fetch_pc = o_pc_ff;
   assign rsp_mem_op        = o_op_ff;
   assign rsp_mem_size      = o_size_ff;
   assign rsp_mem_addr      = o_addr_ff;
   assign rsp_mem_wdata     = o_wdata_ff;
   assign rsp_console_valid = o_cv_ff;
   assign rsp_console_char  = o_char_ff;
   assign rsp_halted        = o_halt_ff;
   assign rsp_illegal       = o_ill_ff;
   assign rsp_retired       = o_ret_ff;

   // an illegal response never retires
   a_ill_ret: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_illegal && rsp_retired)) else $error("illegal retired");
   // illegal always halts
   a_ill_halt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_illegal) |-> rsp_halted) else $error("illegal not halted");
   // once halted, state holds
   a_halt_hold: assert property (@(posedge clock) disable iff (reset)
      (halt_ff && take) |=> (halt_ff && !rsp_retired)) else $error("halt lost");
   // a response stalled downstream keeps the slot full
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped");
endmodule

>>> dv/rv32i_exec_checker.sv
// ---------------------------------------------------------------------------
// rv32i executor checker
// watches the request, response and csr channels of the executor, keeps its
// own copy of the architectural state, predicts each response and compares
// ---------------------------------------------------------------------------
module rv32i_exec_checker
   import rv32i_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_instr_word,
   input  logic [31:0] req_read_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_next_fetch_pc,
   input  logic [1:0]  rsp_mem_op,
   input  logic [1:0]  rsp_mem_size,
   input  logic [31:0] rsp_mem_addr,
   input  logic [31:0] rsp_mem_wdata,
   input  logic        rsp_console_valid,
   input  logic [7:0]  rsp_console_char,
   input  logic        rsp_halted,
   input  logic        rsp_illegal,
   input  logic        rsp_retired,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          errors,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic [31:0] pc;
      logic [1:0]  mop;
      logic [1:0]  msize;
      logic [31:0] maddr;
      logic [31:0] wdata;
      logic        cvalid;
      logic [7:0]  cchar;
      logic        halted;
      logic        illegal;
      logic        retired;
   } exec_result_type;

   exec_result_type expected_q[$];

   logic [31:0] xreg [32];
   logic [31:0] pc_q, mailbox_q, timer_q, limit_q, count_q;
   logic        ld_pend, ld_timer, halted_q;
   logic [4:0]  ld_dest;
   logic [2:0]  ld_kind;

   initial begin
      errors  = 0;
      pending = 0;
      checked = 0;
   end

   task automatic write_xreg(input logic [4:0] rd, input logic [31:0] v);
      if (rd != 5'd0) xreg[rd] = v;
   endtask

   task automatic retire_one(inout exec_result_type r);
      count_q = count_q + 32'd1;
      if (count_q >= limit_q) halted_q = 1'b1;
      r.retired = 1'b1;
   endtask

   task automatic execute_item(input logic op, input logic [31:0] ir,
                               input logic [31:0] rdata, output exec_result_type r);
      logic [31:0] a, b, immi, npc, d, addr, sb;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic        bad, wr, cond, hhalt;
      r     = '0;
      rd    = ir[11:7];
      f3    = ir[14:12];
      f7    = ir[31:25];
      a     = xreg[ir[19:15]];
      b     = xreg[ir[24:20]];
      immi  = {{20{ir[31]}}, ir[31:20]};
      npc   = pc_q + 32'd4;
      d     = '0;
      bad   = 1'b0;
      wr    = 1'b0;
      cond  = 1'b0;
      hhalt = 1'b0;
      if (halted_q) begin
         // halted: everything ignored
      end else if (op) begin
         if (ld_pend) begin
            d = ld_timer ? 32'd0 : rdata;
            case (ld_kind)
               3'd0: d = {{24{d[7]}}, d[7:0]};
               3'd1: d = {{16{d[15]}}, d[15:0]};
               3'd4: d = {24'd0, d[7:0]};
               3'd5: d = {16'd0, d[15:0]};
               default: ;
            endcase
            write_xreg(ld_dest, d);
            ld_pend  = 1'b0;
            ld_timer = 1'b0;
            retire_one(r);
         end
      end else if (!ld_pend) begin
         case (ir[6:0])
            OPC_LOAD: begin
               if (f3 == 3'd3 || f3 >= 3'd6) bad = 1'b1;
               else begin
                  r.mop    = MEM_READ;
                  r.msize  = f3[1:0];
                  r.maddr  = a + immi;
                  ld_pend  = 1'b1;
                  ld_dest  = rd;
                  ld_kind  = f3;
                  ld_timer = (r.maddr == timer_q);
                  pc_q     = npc;
               end
            end
            OPC_STORE: begin
               addr = a + ((immi & STORE_IMM_MASK) | {27'd0, rd});
               if (f3 > 3'd2) bad = 1'b1;
               else if (f3 == 3'd2 && addr == mailbox_q) begin
                  if ((b & HOST_CHAR_BIT) != 0) begin
                     r.cvalid = 1'b1;
                     r.cchar  = b[7:0];
                  end
                  if ((b & HOST_HALT_BIT) != 0) hhalt = 1'b1;
               end else begin
                  r.mop   = MEM_WRITE;
                  r.msize = f3[1:0];
                  r.maddr = addr;
                  r.wdata = b;
               end
            end
            OPC_OPIMM: begin
               wr = 1'b1;
               case (f3)
                  3'd0: d = a + immi;
                  3'd1: if (ir[31:25] != 0) bad = 1'b1; else d = a << ir[24:20];
                  3'd2: d = ($signed(a) < $signed(immi)) ? 32'd1 : 32'd0;
                  3'd3: d = (a < immi) ? 32'd1 : 32'd0;
                  3'd4: d = a ^ immi;
                  3'd5: begin
                     if (ir[31] || ir[29:25] != 0) bad = 1'b1;
                     else if (ir[30]) d = $signed(a) >>> ir[24:20];
                     else d = a >> ir[24:20];
                  end
                  3'd6: d = a | immi;
                  default: d = a & immi;
               endcase
            end
            OPC_OP: begin
               wr = 1'b1;
               if (f7 != 0 && !(f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))) bad = 1'b1;
               else case (f3)
                  3'd0: d = (f7 != 0) ? a - b : a + b;
                  3'd1: d = a << b[4:0];
                  3'd2: d = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                  3'd3: d = (a < b) ? 32'd1 : 32'd0;
                  3'd4: d = a ^ b;
                  3'd5: d = (f7 != 0) ? $unsigned($signed(a) >>> b[4:0]) : a >> b[4:0];
                  3'd6: d = a | b;
                  default: d = a & b;
               endcase
            end
            OPC_AUIPC: begin
               wr = 1'b1;
               d  = pc_q + (ir & UPPER_IMM_MASK);
            end
            OPC_LUI: begin
               wr = 1'b1;
               d  = ir & UPPER_IMM_MASK;
            end
            OPC_BRANCH: begin
               case (f3)
                  3'd0: cond = (a == b);
                  3'd1: cond = (a != b);
                  3'd4: cond = $signed(a) < $signed(b);
                  3'd5: cond = !($signed(a) < $signed(b));
                  3'd6: cond = a < b;
                  3'd7: cond = a >= b;
                  default: bad = 1'b1;
               endcase
               sb = {{20{ir[31]}}, ir[7], ir[30:25], ir[11:8], 1'b0};
               if (cond) npc = pc_q + sb;
            end
            OPC_JALR: begin
               if (f3 != 0) bad = 1'b1;
               else begin
                  wr  = 1'b1;
                  d   = pc_q + 32'd4;
                  npc = (a + immi) & ~32'd1;
               end
            end
            OPC_JAL: begin
               wr  = 1'b1;
               d   = pc_q + 32'd4;
               npc = pc_q + {{12{ir[31]}}, ir[19:12], ir[20], ir[30:21], 1'b0};
            end
            default: bad = 1'b1;
         endcase
         if (bad) begin
            r         = '0;
            r.illegal = 1'b1;
            halted_q  = 1'b1;
         end else if (ir[6:0] != OPC_LOAD) begin
            if (wr) write_xreg(rd, d);
            pc_q = npc;
            retire_one(r);
            if (hhalt) halted_q = 1'b1;
         end
      end
      r.pc     = pc_q;
      r.halted = halted_q;
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h (response %0d)",
               field, got, want, checked);
      errors++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(field, got, want);
   endtask

   always @(posedge clock) begin
      exec_result_type e, p;
      if (reset) begin
         foreach (xreg[i]) xreg[i] = '0;
         pc_q      = '0;
         mailbox_q = MAILBOX_RESET;
         timer_q   = TIMER_RESET;
         limit_q   = LIMIT_RESET;
         count_q   = '0;
         ld_pend   = 1'b0;
         ld_timer  = 1'b0;
         ld_dest   = '0;
         ld_kind   = '0;
         halted_q  = 1'b0;
         expected_q.delete();
      end else begin
         // responses first: a response at this edge never belongs to a
         // request accepted at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected response pc", rsp_next_fetch_pc, '0);
            end else begin
               e = expected_q.pop_front();
               check_field("next_fetch_pc", rsp_next_fetch_pc, e.pc);
               check_field("mem_op", rsp_mem_op, e.mop);
               check_field("mem_size", rsp_mem_size, e.msize);
               check_field("mem_addr", rsp_mem_addr, e.maddr);
               check_field("mem_wdata", rsp_mem_wdata, e.wdata);
               check_field("console_valid", rsp_console_valid, e.cvalid);
               check_field("console_char", rsp_console_char, e.cchar);
               check_field("halted", rsp_halted, e.halted);
               check_field("illegal", rsp_illegal, e.illegal);
               check_field("retired", rsp_retired, e.retired);
            end
            checked++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RESET_VECTOR: pc_q = csr_data;
               CSR_HOST_MAILBOX: mailbox_q = csr_data;
               CSR_TIMER_ADDR:   timer_q = csr_data;
               CSR_CYCLE_LIMIT:  limit_q = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            execute_item(req_opcode, req_instr_word, req_read_data, p);
            expected_q.push_back(p);
         end
      end
      pending = expected_q.size();
   end

endmodule

>>> dv/tb.sv
// ---------------------------------------------------------------------------
// rv32i executor testbench
// drives directed and random instruction streams with load returns into the
// executor under several idle and stall patterns, and ends with one halt
// ---------------------------------------------------------------------------
module tb;
   import rv32i_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [31:0] req_instr_word = '0;
   logic [31:0] req_read_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_next_fetch_pc;
   logic [1:0]  rsp_mem_op;
   logic [1:0]  rsp_mem_size;
   logic [31:0] rsp_mem_addr;
   logic [31:0] rsp_mem_wdata;
   logic        rsp_console_valid;
   logic [7:0]  rsp_console_char;
   logic        rsp_halted;
   logic        rsp_illegal;
   logic        rsp_retired;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   int errors, pending, checked;
   int send_idle = 0;     // percent of cycles the sender holds off
   int recv_stall = 0;    // percent of cycles the receiver stalls
   int items_sent = 0;
   int cycle_count = 0;
   logic [31:0] mailbox_cfg = MAILBOX_RESET;
   logic [31:0] timer_cfg = TIMER_RESET;

   localparam int CYCLE_LIMIT = 400000;

   rv32i_instruction_executor uut (.*);

   rv32i_exec_checker checker_i (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver stall pattern, redrawn every cycle
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // instruction encoders
   function automatic logic [31:0] enc_i(opcode_type opc, logic [4:0] rd,
                                         logic [2:0] f3, logic [4:0] rs1,
                                         logic [11:0] imm);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2,
                                         logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OPC_OP};
   endfunction

   function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs2,
                                         logic [4:0] rs1, logic [11:0] imm);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
   endfunction

   function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1,
                                         logic [4:0] rs2, logic [12:0] off);
      return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
   endfunction

   // random legal instruction: no illegal encodings so the run keeps going
   function automatic logic [31:0] random_legal();
      logic [31:0] w;
      logic [2:0]  f3;
      w  = $urandom;
      f3 = w[14:12];
      case ($urandom_range(8))
         0: w[6:0] = OPC_LUI;
         1: w[6:0] = OPC_AUIPC;
         2: w[6:0] = OPC_JAL;
         3: begin
            w[6:0] = OPC_JALR;
            w[14:12] = 3'd0;
         end
         4: begin
            w[6:0] = OPC_BRANCH;
            if (f3 == 3'd2 || f3 == 3'd3) w[14] = 1'b1;
         end
         5: begin
            w[6:0] = OPC_LOAD;
            if (f3 == 3'd3 || f3 >= 3'd6) w[14:12] = {f3[1:0] & 2'd1, 1'b0};
         end
         6: begin
            w[6:0] = OPC_STORE;
            if (f3 > 3'd2) w[14:12] = {1'b0, f3[1:0] & 2'd2};
         end
         7: begin
            w[6:0] = OPC_OPIMM;
            if (f3 == 3'd1) w[31:25] = 7'h00;
            if (f3 == 3'd5) w[31:25] = w[30] ? 7'h20 : 7'h00;
         end
         default: begin
            w[6:0] = OPC_OP;
            w[31:25] = (w[30] && (f3 == 3'd0 || f3 == 3'd5)) ? 7'h20 : 7'h00;
         end
      endcase
      return w;
   endfunction

   // one request transfer; valid stays high until the next hold-off
   task automatic send(input logic op, input logic [31:0] ir, input logic [31:0] rd);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_opcode     <= op;
      req_instr_word <= ir;
      req_read_data  <= rd;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic exec(input logic [31:0] ir);
      send(1'b0, ir, $urandom);
   endtask

   task automatic load_return(input logic [31:0] rd);
      send(1'b1, $urandom, rd);
   endtask

   // lui + addi into rd
   task automatic set_reg(input logic [4:0] rd, input logic [31:0] v);
      logic [31:0] hi;
      hi = v + 32'h800;
      exec({hi[31:12], rd, OPC_LUI});
      exec(enc_i(OPC_OPIMM, rd, 3'd0, rd, v[11:0]));
   endtask

   // wait until every response is in, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] v);
      csr_index <= idx;
      csr_data  <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] rv, input logic [31:0] mb,
                            input logic [31:0] tm, input logic [31:0] lim);
      drain();
      csr_write(CSR_RESET_VECTOR, rv);
      csr_write(CSR_HOST_MAILBOX, mb);
      csr_write(CSR_TIMER_ADDR, tm);
      csr_write(CSR_CYCLE_LIMIT, lim);
      mailbox_cfg = mb;
      timer_cfg   = tm;
   endtask

   // mostly well-formed streams: loads are followed by their data return,
   // with some broken sequences and stray returns mixed in
   task automatic random_item();
      logic [31:0] w;
      int r;
      r = $urandom_range(99);
      if (r < 6) begin
         load_return($urandom);  // stray return when nothing is pending
      end else begin
         w = random_legal();
         exec(w);
         if (w[6:0] == OPC_LOAD) begin
            if ($urandom_range(99) < 15) exec(random_legal());  // ignored while pending
            load_return($urandom);
         end
      end
   endtask

   task automatic directed();
      // extremes of the immediates
      exec({20'hfffff, 5'd5, OPC_LUI});
      exec(enc_i(OPC_OPIMM, 5'd6, 3'd0, 5'd0, 12'h800));
      exec(enc_i(OPC_OPIMM, 5'd7, 3'd0, 5'd0, 12'h7ff));
      exec(enc_i(OPC_OPIMM, 5'd0, 3'd0, 5'd7, 12'h001));           // x0 stays zero
      exec({7'h20, 5'd31, 5'd6, 3'd5, 5'd10, OPC_OPIMM});          // srai by 31
      exec(enc_r(7'h20, 5'd7, 5'd6, 3'd0, 5'd11));                 // sub
      exec(enc_r(7'h20, 5'd7, 5'd6, 3'd5, 5'd12));                 // sra
      exec(enc_r(7'h00, 5'd6, 5'd7, 3'd3, 5'd13));                 // sltu
      exec(enc_r(7'h00, 5'd6, 5'd7, 3'd2, 5'd14));                 // slt
      exec({20'h12345, 5'd15, OPC_AUIPC});
      // mailbox stores: console character, no bits, byte and halfword to memory
      set_reg(5'd1, mailbox_cfg);
      set_reg(5'd2, HOST_CHAR_BIT | 32'h41);
      exec(enc_s(3'd2, 5'd2, 5'd1, 12'd0));
      exec(enc_s(3'd2, 5'd0, 5'd1, 12'd0));
      exec(enc_s(3'd0, 5'd2, 5'd1, 12'd0));
      exec(enc_s(3'd1, 5'd2, 5'd1, 12'd0));
      // timer load reads zero whatever comes back
      set_reg(5'd3, timer_cfg);
      exec(enc_i(OPC_LOAD, 5'd4, 3'd2, 5'd3, 12'd0));
      load_return(32'hffffffff);
      exec(enc_i(OPC_LOAD, 5'd8, 3'd0, 5'd3, 12'd0));
      load_return(32'h80);
      // sign and zero extension, with a broken sequence in the middle
      exec(enc_i(OPC_LOAD, 5'd9, 3'd0, 5'd7, 12'd1));
      exec(enc_i(OPC_OPIMM, 5'd9, 3'd0, 5'd0, 12'd5));             // ignored while pending
      load_return(32'h80);
      exec(enc_i(OPC_LOAD, 5'd16, 3'd5, 5'd7, 12'd1));
      load_return(32'hffff8001);
      load_return(32'h1234);                                       // return with nothing pending
      // control flow
      exec(enc_b(3'd1, 5'd6, 5'd7, 13'h1ff0));                     // taken backwards
      exec(enc_b(3'd0, 5'd6, 5'd7, 13'h0ff0));                     // not taken
      exec({1'b1, 10'h3ff, 1'b1, 8'hff, 5'd17, OPC_JAL});
      exec(enc_i(OPC_JALR, 5'd18, 3'd0, 5'd7, 12'h001));           // target x7 + 1 is already even
   endtask

   // the run can halt only once; pick one of the halting causes
   task automatic halt_phase();
      logic [31:0] w;
      case ($urandom_range(2))
         0: begin
            case ($urandom_range(4))
               0: w = {$urandom} & 32'hffffff80 | {25'd0, $urandom_range(1) ? 7'h0f : 7'h73};
               1: w = enc_i(OPC_LOAD, 5'd1, 3'd3, 5'd2, 12'd0);
               2: w = enc_i(OPC_JALR, 5'd1, 3'd1, 5'd2, 12'd0);
               3: w = {7'h01, 5'd3, 5'd2, 3'd1, 5'd1, OPC_OPIMM};
               default: w = enc_r(7'h20, 5'd3, 5'd2, 3'd4, 5'd1);
            endcase
            exec(w);
         end
         1: begin
            set_reg(5'd1, mailbox_cfg);
            set_reg(5'd2, HOST_HALT_BIT | HOST_CHAR_BIT | 32'h5a);
            exec(enc_s(3'd2, 5'd2, 5'd1, 12'd0));
         end
         default: begin
            drain();
            csr_write(CSR_CYCLE_LIMIT, 32'd1);
            exec(enc_i(OPC_OPIMM, 5'd1, 3'd0, 5'd1, 12'd1));
         end
      endcase
      // everything after the halt is ignored
      repeat (8) send(1'($urandom_range(1)), $urandom, $urandom);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      configure(32'h0, MAILBOX_RESET, TIMER_RESET, 32'hffffffff);
      directed();

      // phase 1: no idling
      send_idle = 0; recv_stall = 0;
      repeat (125) random_item();

      // phase 2: sender mostly idle, extreme addresses
      configure(32'hfffffffc, 32'hffffffff, 32'h0, 32'hfffffff0);
      send_idle = 76; recv_stall = 0;
      directed();
      repeat (110) random_item();

      // phase 3: receiver mostly stalling
      configure($urandom, $urandom, $urandom, 32'h80000000 | $urandom);
      send_idle = 0; recv_stall = 76;
      repeat (60) random_item();
      drain();  // sender pauses until all responses are back
      repeat (60) random_item();

      // phase 4: both sides idle now and then
      configure($urandom & 32'hfffffffc, 32'h0, 32'hffffffff, 32'hffffffff);
      send_idle = 17; recv_stall = 17;
      repeat (125) random_item();

      halt_phase();

      drain();
      repeat (10) @(negedge clock);
      $display("sent %0d requests, checked %0d responses over four idle patterns and a halt",
               items_sent, checked);
      if (errors == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
